>>> hdl/assert_macros.svh
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside reset.
`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  `ASSERT_PROP(lbl, !(cond), msg)

`endif

>>> hdl/mlft_pkg.sv
// Package with constants, codes and types of the MAC forwarding table.
package mlft_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int PORT_COUNT    = 16;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int MAC_W         = 48;
  localparam int PORT_W        = 4;
  localparam int ACT_W         = 2;

  localparam logic [MAC_W-1:0] BCAST_ADDR = {MAC_W{1'b1}};

  typedef enum logic {
    OP_REGISTER = 1'b0,
    OP_FORWARD  = 1'b1
  } op_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_LINK_ACK  = 2'd0,
    ACT_UNICAST   = 2'd1,
    ACT_BROADCAST = 2'd2,
    ACT_DROP      = 2'd3
  } action_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic load;
    logic commit;
  } dp_cmd_t;

endpackage

>>> hdl/mlft_if.sv
// Valid/ready channel interfaces for items and results.
interface mlft_in_if;
  logic                         valid;
  logic                         ready;
  logic                         operation;
  logic [mlft_pkg::PORT_W-1:0]  source_port;
  logic [mlft_pkg::MAC_W-1:0]   mac_address;

  modport source (output valid, output operation, output source_port,
                  output mac_address, input ready);
  modport sink   (input valid, input operation, input source_port,
                  input mac_address, output ready);
endinterface

interface mlft_out_if;
  logic                         valid;
  logic                         ready;
  logic [mlft_pkg::ACT_W-1:0]   action;
  logic [mlft_pkg::PORT_W-1:0]  dest_port;
  logic                         table_full;

  modport source (output valid, output action, output dest_port,
                  output table_full, input ready);
  modport sink   (input valid, input action, input dest_port,
                  input table_full, output ready);
endinterface

>>> hdl/mlft_ctrl.sv
// Controller state machine: sequences accept, table update and result hold.
module mlft_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output mlft_pkg::dp_cmd_t cmd
);

  mlft_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             commit;

  assign commit = (state_r == mlft_pkg::ST_EXEC) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mlft_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = mlft_pkg::ST_EXEC;
      end
      mlft_pkg::ST_EXEC: begin
        if (commit) state_nxt = mlft_pkg::ST_IDLE;
      end
      default: state_nxt = mlft_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd.load   = 1'b0;
    cmd.commit = 1'b0;
    unique case (state_r)
      mlft_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      mlft_pkg::ST_EXEC: begin
        cmd.commit = commit;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign out_valid_nxt = commit || (out_valid_r && !out_ready);
  assign out_valid     = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mlft_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> hdl/mlft_dp.sv
// Datapath: item register, entry table, parallel match and result register.
module mlft_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mlft_pkg::dp_cmd_t           cmd,
  input  logic                        in_operation,
  input  logic [mlft_pkg::PORT_W-1:0] in_source_port,
  input  logic [mlft_pkg::MAC_W-1:0]  in_mac_address,
  output logic [mlft_pkg::ACT_W-1:0]  out_action,
  output logic [mlft_pkg::PORT_W-1:0] out_dest_port,
  output logic                        out_table_full
);

  localparam int N = mlft_pkg::TABLE_ENTRIES;

  logic                        op_r;
  logic [mlft_pkg::PORT_W-1:0] src_r;
  logic [mlft_pkg::MAC_W-1:0]  mac_r;

  logic [N-1:0]                valid_r;
  logic [mlft_pkg::MAC_W-1:0]  addr_r [N];
  logic [mlft_pkg::PORT_W-1:0] port_r [N];

  mlft_pkg::action_t           action_r, action_nxt;
  logic [mlft_pkg::PORT_W-1:0] dest_r, dest_nxt;
  logic                        full_r, full_nxt;

  logic [N-1:0]                match;
  logic                        hit, free_any, src_ok, wr_en;
  logic [mlft_pkg::IDX_W-1:0]  hit_idx, free_idx, wr_idx;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      match[i] = valid_r[i] && (addr_r[i] == mac_r);
    end
  end

  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (match[i])    hit_idx  = mlft_pkg::IDX_W'(i);
      if (!valid_r[i]) free_idx = mlft_pkg::IDX_W'(i);
    end
  end

  assign hit      = |match;
  assign free_any = ~&valid_r;
  assign src_ok   = int'(src_r) < mlft_pkg::PORT_COUNT;

  always_comb begin
    action_nxt = mlft_pkg::ACT_DROP;
    dest_nxt   = '0;
    full_nxt   = 1'b0;
    wr_en      = 1'b0;
    wr_idx     = hit ? hit_idx : free_idx;
    if (!src_ok) begin
      dest_nxt = src_r;
    end else if (op_r == mlft_pkg::OP_REGISTER) begin
      action_nxt = mlft_pkg::ACT_LINK_ACK;
      dest_nxt   = src_r;
      wr_en      = hit || free_any;
      full_nxt   = !(hit || free_any);
    end else if (mac_r == mlft_pkg::BCAST_ADDR) begin
      action_nxt = mlft_pkg::ACT_BROADCAST;
      dest_nxt   = src_r;
    end else if (hit) begin
      action_nxt = mlft_pkg::ACT_UNICAST;
      dest_nxt   = port_r[hit_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_operation;
      src_r <= in_source_port;
      mac_r <= in_mac_address;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.commit && wr_en) begin
      valid_r[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && wr_en) begin
      addr_r[wr_idx] <= mac_r;
      port_r[wr_idx] <= src_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      action_r <= action_nxt;
      dest_r   <= dest_nxt;
      full_r   <= full_nxt;
    end
  end

  assign out_action     = action_r;
  assign out_dest_port  = dest_r;
  assign out_table_full = full_r;

endmodule

>>> hdl/mac_learning_forward_table.sv
// Top level of the layer-2 MAC learning and forwarding table.
// Usage:
//   in_ch carries one transaction per item: operation (register host address
//   or forward packet), source_port and a 48-bit mac_address.
//   out_ch returns exactly one result per item: action, dest_port, table_full.
//   Both channels transfer when valid and ready are high at a rising clk edge.
// Each item is latched in the item register when accepted; the 16-entry parallel
//   address match, table update and result load follow when the controller
//   commits it, which waits while an earlier result is still stalled in the
//   output register. No new item is accepted until that commit.
// An item may be accepted while an earlier result still waits in the output
//   register; the controller then holds the new item until that result leaves.
// Reset (rst_n low, synchronous) clears all entry valid bits, empties the
//   output register and returns the controller to idle.
// When out_ch.ready stays low the result and its valid hold steady.
module mac_learning_forward_table (
  input  logic clk,
  input  logic rst_n,
  mlft_in_if.sink    in_ch,
  mlft_out_if.source out_ch
);

  mlft_pkg::dp_cmd_t cmd;

  mlft_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  mlft_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_operation   (in_ch.operation),
    .in_source_port (in_ch.source_port),
    .in_mac_address (in_ch.mac_address),
    .out_action     (out_ch.action),
    .out_dest_port  (out_ch.dest_port),
    .out_table_full (out_ch.table_full)
  );

endmodule

>>> hdl/mlft_chk.sv
// Port-level checker for the MAC forwarding table, bound to the top level.
`include "assert_macros.svh"

module mlft_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [mlft_pkg::ACT_W-1:0]  out_action,
  input logic [mlft_pkg::PORT_W-1:0] out_dest_port,
  input logic                        out_table_full
);

  `ASSERT_PROP(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
  `ASSERT_PROP(a_out_stable, out_valid && !out_ready |=> $stable(out_action) && $stable(out_dest_port) && $stable(out_table_full), "stalled result changed")
  `ASSERT_PROP(a_one_item, in_valid && in_ready |=> !in_ready, "second transaction taken while one is in work")
  `ASSERT_NEVER(a_full_ack, out_valid && out_table_full && (out_action != mlft_pkg::ACT_LINK_ACK), "table_full on a non-ack result")

endmodule

bind mac_learning_forward_table mlft_chk u_mlft_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_action     (out_ch.action),
  .out_dest_port  (out_ch.dest_port),
  .out_table_full (out_ch.table_full)
);
